// ----- hdl/mp3fhp_pkg.sv -----
// Shared types, constants and header decode functions of the MP3 frame header parser.
`default_nettype none

package mp3fhp_pkg;

    localparam int POS_W = 30;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam int DIV_DIVIDEND_W = 29;
    localparam int DIV_QUOT_W     = 11;
    localparam int DIV_DIVISOR_W  = DIV_DIVIDEND_W - (DIV_QUOT_W - 1);
    localparam int DIV_CNT_W      = $clog2(DIV_QUOT_W);

    localparam logic [23:0] ID3_MAGIC = 24'h494433;

    localparam logic [2:0] STAT_OK            = 3'd0;
    localparam logic [2:0] STAT_NO_SYNC       = 3'd1;
    localparam logic [2:0] STAT_BAD_VERSION   = 3'd2;
    localparam logic [2:0] STAT_NOT_LAYER3    = 3'd3;
    localparam logic [2:0] STAT_RESERVED_RATE = 3'd4;
    localparam logic [2:0] STAT_TOO_SHORT     = 3'd5;

    localparam logic [1:0] VER_MPEG1   = 2'd1;
    localparam logic [1:0] VER_MPEG2   = 2'd2;
    localparam logic [1:0] VCODE_MPEG1 = 2'b11;
    localparam logic [1:0] VCODE_MPEG2 = 2'b10;
    localparam logic [1:0] LAYER3_CODE = 2'b01;
    localparam logic [1:0] SI_RESERVED = 2'b11;
    localparam logic [1:0] MONO_MODE   = 2'b11;

    localparam logic [20:0] SCALE_MPEG1 = 21'd1152000;
    localparam logic [20:0] SCALE_MPEG2 = 21'd576000;

    typedef enum logic [2:0] {
        PH_TAG_UNKNOWN,
        PH_TAG_ID3,
        PH_TAG_PLAIN,
        PH_HOLD,
        PH_SEARCH,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_START,
        ST_DIV
    } t_ctl_state;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  version;
        logic [8:0]  bitrate;
        logic [15:0] sample_rate;
        logic        padding;
        logic [1:0]  channels;
    } t_hdr;

    function automatic logic [8:0] kbps_lookup(input logic lsf, input logic [3:0] idx);
        logic [8:0] v;
        v = '0;
        if (!lsf) begin
            case (idx)
                4'd1:    v = 9'd32;
                4'd2:    v = 9'd40;
                4'd3:    v = 9'd48;
                4'd4:    v = 9'd56;
                4'd5:    v = 9'd64;
                4'd6:    v = 9'd80;
                4'd7:    v = 9'd96;
                4'd8:    v = 9'd112;
                4'd9:    v = 9'd128;
                4'd10:   v = 9'd160;
                4'd11:   v = 9'd192;
                4'd12:   v = 9'd224;
                4'd13:   v = 9'd256;
                4'd14:   v = 9'd320;
                default: v = 9'd0;
            endcase
        end else begin
            case (idx)
                4'd1:    v = 9'd8;
                4'd2:    v = 9'd16;
                4'd3:    v = 9'd24;
                4'd4:    v = 9'd32;
                4'd5:    v = 9'd40;
                4'd6:    v = 9'd48;
                4'd7:    v = 9'd56;
                4'd8:    v = 9'd64;
                4'd9:    v = 9'd80;
                4'd10:   v = 9'd96;
                4'd11:   v = 9'd112;
                4'd12:   v = 9'd128;
                4'd13:   v = 9'd144;
                4'd14:   v = 9'd160;
                default: v = 9'd0;
            endcase
        end
        return v;
    endfunction

    function automatic logic [15:0] hz_lookup(input logic lsf, input logic [1:0] idx);
        logic [15:0] v;
        case ({lsf, idx})
            3'b000:  v = 16'd44100;
            3'b001:  v = 16'd48000;
            3'b010:  v = 16'd32000;
            3'b100:  v = 16'd22050;
            3'b101:  v = 16'd24000;
            3'b110:  v = 16'd16000;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    function automatic logic is_sync(input logic [31:0] w);
        return (w[31:24] == 8'hff) && (w[23:21] == 3'b111);
    endfunction

    function automatic t_hdr decode_header(input logic [31:0] w);
        t_hdr h;
        logic lsf;
        h = '0;
        case (w[20:19])
            VCODE_MPEG1: h.version = VER_MPEG1;
            VCODE_MPEG2: h.version = VER_MPEG2;
            default:     h.status  = STAT_BAD_VERSION;
        endcase
        if (h.status == STAT_OK && w[18:17] != LAYER3_CODE) begin
            h.status = STAT_NOT_LAYER3;
        end else if (h.status == STAT_OK && w[11:10] == SI_RESERVED) begin
            h.status = STAT_RESERVED_RATE;
        end
        lsf = (h.version == VER_MPEG2);
        if (h.status == STAT_OK) begin
            h.bitrate     = kbps_lookup(lsf, w[15:12]);
            h.sample_rate = hz_lookup(lsf, w[11:10]);
            h.padding     = w[9];
            h.channels    = (w[7:6] == MONO_MODE) ? 2'd1 : 2'd2;
        end else begin
            h.version = '0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/mp3fhp_div.sv -----
// Iterative restoring divider that produces one quotient bit per cycle for the frame length.
`default_nettype none

module mp3fhp_div
    import mp3fhp_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [DIV_DIVIDEND_W-1:0] i_dividend,
    input  wire logic [DIV_DIVISOR_W-1:0]  i_divisor,
    output logic                           o_done,
    output logic [DIV_QUOT_W-1:0]          o_quot
);

    logic                      r_busy;
    logic [DIV_CNT_W-1:0]      r_cnt;
    logic [DIV_DIVIDEND_W-1:0] r_rem;
    logic [DIV_DIVIDEND_W-1:0] r_dsr;
    logic [DIV_QUOT_W-2:0]     r_q;
    logic                      c_ge;
    logic [DIV_DIVIDEND_W-1:0] c_sub;

    assign c_ge   = (r_rem >= r_dsr);
    assign c_sub  = r_rem - r_dsr;
    assign o_done = r_busy && (r_cnt == '0);
    assign o_quot = {r_q, c_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_QUOT_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_dsr <= {i_divisor, {(DIV_QUOT_W-1){1'b0}}};
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= c_ge ? c_sub : r_rem;
            r_dsr <= r_dsr >> 1;
            r_q   <= {r_q[DIV_QUOT_W-3:0], c_ge};
        end
    end

endmodule

`default_nettype wire

// ----- hdl/mp3_frame_header_parser.sv -----
// Top level of the MP3 frame header parser: byte scanner, header decode and frame length sequencer.
// The input channel takes one stream byte per request (i_data_byte with the i_first_byte
// and i_last_byte marks) and the output channel gives one result per stream.
// A byte that gives no result, or that ends the stream in an error, leaves the sequencer idle;
// an error result appears on the output in the cycle after its byte is accepted.
// A byte that completes a valid Layer III header starts the frame length sequence: the
// multiplier state, the divider load state and the divide state that waits for the divider,
// after which the result is registered on the output; o_in_stall is high meanwhile.
// The divider makes one compare-and-subtract per cycle, one per quotient bit.
// A first-byte mark clears the scan state before the byte is taken, also mid-stream.
// After the result of a stream, bytes are accepted and dropped until the next first byte.
// The result sits in an output register; while the receiver holds i_out_stall with a result
// waiting, new bytes are held off with o_in_stall, and the result stays unchanged.
// Synchronous reset clears the scan state, the sequencer and the output valid flag.
`default_nettype none

module mp3_frame_header_parser
    import mp3fhp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_first_byte,
    input  wire logic        i_last_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_status,
    output logic [1:0]       o_mpeg_version,
    output logic [8:0]       o_bitrate_kbps,
    output logic [15:0]      o_sample_rate_hz,
    output logic             o_padding_bit,
    output logic [1:0]       o_channel_count,
    output logic [10:0]      o_frame_bytes,
    output logic [29:0]      o_audio_offset
);

    t_ctl_state r_state, n_state;
    t_phase     r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_skip, n_skip;
    logic [31:0]      r_win, n_win;
    logic             r_given, n_given;
    t_hdr             r_hdr, n_hdr;
    logic [DIV_DIVIDEND_W-1:0] r_prod, n_prod;

    logic        r_o_valid, n_o_valid;
    logic [2:0]  r_o_status, n_o_status;
    logic [1:0]  r_o_ver, n_o_ver;
    logic [8:0]  r_o_br, n_o_br;
    logic [15:0] r_o_sr, n_o_sr;
    logic        r_o_pad, n_o_pad;
    logic [1:0]  r_o_ch, n_o_ch;
    logic [10:0] r_o_fb, n_o_fb;
    logic [29:0] r_o_off, n_o_off;

    logic             c_acc;
    t_phase           c_phase;
    logic [POS_W-1:0] c_pos;
    logic [POS_W-1:0] c_skip;
    logic [31:0]      c_win;
    logic             c_given;
    logic [31:0]      c_win_new;
    t_hdr             c_hdr;
    logic             c_sync;
    logic [28:0]      c_tag_size;
    logic [20:0]      c_scale;
    logic [29:0]      c_prod;

    logic                     div_start;
    logic                     div_done;
    logic [DIV_QUOT_W-1:0]    div_quot;

    assign o_in_stall = (r_state != ST_IDLE) || (r_o_valid && i_out_stall);
    assign c_acc      = i_in_valid && !o_in_stall;

    assign c_phase   = i_first_byte ? PH_TAG_UNKNOWN : r_phase;
    assign c_pos     = i_first_byte ? '0 : r_pos;
    assign c_skip    = i_first_byte ? '0 : r_skip;
    assign c_win     = i_first_byte ? '0 : r_win;
    assign c_given   = i_first_byte ? 1'b0 : r_given;
    assign c_win_new = (c_phase != PH_HOLD) ? {c_win[23:0], i_data_byte} : c_win;
    assign c_hdr     = decode_header(c_win_new);
    assign c_sync    = is_sync(c_win_new);

    assign c_tag_size = {c_win_new[31:24], 21'b0} | {7'b0, c_win_new[23:16], 14'b0} |
                        {14'b0, c_win_new[15:8], 7'b0} | {21'b0, c_win_new[7:0]};

    assign c_scale = (r_hdr.version == VER_MPEG1) ? SCALE_MPEG1 : SCALE_MPEG2;
    assign c_prod  = 30'(r_hdr.bitrate) * 30'(c_scale);

    mp3fhp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  ({r_hdr.sample_rate, 3'b000}),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        logic v_dec;
        v_dec      = 1'b0;
        n_state    = r_state;
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_skip     = r_skip;
        n_win      = r_win;
        n_given    = r_given;
        n_hdr      = r_hdr;
        n_prod     = r_prod;
        div_start  = 1'b0;
        n_o_valid  = r_o_valid && i_out_stall;
        n_o_status = r_o_status;
        n_o_ver    = r_o_ver;
        n_o_br     = r_o_br;
        n_o_sr     = r_o_sr;
        n_o_pad    = r_o_pad;
        n_o_ch     = r_o_ch;
        n_o_fb     = r_o_fb;
        n_o_off    = r_o_off;

        case (r_state)
            ST_IDLE: begin
                if (c_acc) begin
                    n_phase = c_phase;
                    n_pos   = c_pos;
                    n_skip  = c_skip;
                    n_win   = c_win;
                    n_given = c_given;
                    if (!c_given) begin
                        n_win = c_win_new;
                        case (c_phase)
                            PH_TAG_UNKNOWN: begin
                                if (c_pos >= POS_W'(2)) begin
                                    n_phase = (c_win_new[23:0] == ID3_MAGIC) ?
                                              PH_TAG_ID3 : PH_TAG_PLAIN;
                                end
                            end
                            PH_TAG_ID3: begin
                                if (c_pos >= POS_W'(9)) begin
                                    n_skip  = {1'b0, c_tag_size} + POS_W'(10);
                                    n_phase = PH_SEARCH;
                                end
                            end
                            PH_TAG_PLAIN: begin
                                if (c_pos >= POS_W'(3) && c_sync) begin
                                    if (c_pos >= POS_W'(9)) begin
                                        v_dec = 1'b1;
                                    end else begin
                                        n_phase = PH_HOLD;
                                    end
                                end else if (c_pos >= POS_W'(9)) begin
                                    n_phase = PH_SEARCH;
                                end
                            end
                            PH_HOLD: begin
                                if (c_pos >= POS_W'(9)) begin
                                    v_dec = 1'b1;
                                end
                            end
                            PH_SEARCH: begin
                                if ({1'b0, c_pos} >= ({1'b0, c_skip} + 31'd3) && c_sync) begin
                                    v_dec = 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase

                        n_pos = (c_pos != POS_MAX) ? c_pos + 1'b1 : c_pos;

                        if (v_dec) begin
                            n_given = 1'b1;
                            n_phase = PH_DONE;
                            n_o_off = n_skip;
                            if (c_hdr.status != STAT_OK) begin
                                n_o_valid  = 1'b1;
                                n_o_status = c_hdr.status;
                                n_o_ver    = '0;
                                n_o_br     = '0;
                                n_o_sr     = '0;
                                n_o_pad    = 1'b0;
                                n_o_ch     = '0;
                                n_o_fb     = '0;
                            end else begin
                                n_hdr   = c_hdr;
                                n_state = ST_MUL;
                            end
                        end else if (i_last_byte) begin
                            n_given    = 1'b1;
                            n_phase    = PH_DONE;
                            n_o_valid  = 1'b1;
                            n_o_status = (n_phase == PH_SEARCH || c_phase == PH_SEARCH ||
                                          (c_phase == PH_TAG_PLAIN && c_pos >= POS_W'(9)) ||
                                          (c_phase == PH_TAG_ID3 && c_pos >= POS_W'(9))) ?
                                         STAT_NO_SYNC : STAT_TOO_SHORT;
                            n_o_ver    = '0;
                            n_o_br     = '0;
                            n_o_sr     = '0;
                            n_o_pad    = 1'b0;
                            n_o_ch     = '0;
                            n_o_fb     = '0;
                            n_o_off    = n_skip;
                        end
                    end
                end
            end
            ST_MUL: begin
                n_prod  = c_prod[DIV_DIVIDEND_W-1:0];
                n_state = ST_START;
            end
            ST_START: begin
                div_start = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_o_valid  = 1'b1;
                    n_o_status = STAT_OK;
                    n_o_ver    = r_hdr.version;
                    n_o_br     = r_hdr.bitrate;
                    n_o_sr     = r_hdr.sample_rate;
                    n_o_pad    = r_hdr.padding;
                    n_o_ch     = r_hdr.channels;
                    n_o_fb     = div_quot + {{(DIV_QUOT_W-1){1'b0}}, r_hdr.padding};
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_TAG_UNKNOWN;
            r_pos     <= '0;
            r_skip    <= '0;
            r_win     <= '0;
            r_given   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_skip    <= n_skip;
            r_win     <= n_win;
            r_given   <= n_given;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr      <= n_hdr;
        r_prod     <= n_prod;
        r_o_status <= n_o_status;
        r_o_ver    <= n_o_ver;
        r_o_br     <= n_o_br;
        r_o_sr     <= n_o_sr;
        r_o_pad    <= n_o_pad;
        r_o_ch     <= n_o_ch;
        r_o_fb     <= n_o_fb;
        r_o_off    <= n_o_off;
    end

    assign o_out_valid      = r_o_valid;
    assign o_status         = r_o_status;
    assign o_mpeg_version   = r_o_ver;
    assign o_bitrate_kbps   = r_o_br;
    assign o_sample_rate_hz = r_o_sr;
    assign o_padding_bit    = r_o_pad;
    assign o_channel_count  = r_o_ch;
    assign o_frame_bytes    = r_o_fb;
    assign o_audio_offset   = r_o_off;

endmodule

`default_nettype wire

// ----- verif/tb_mp3_frame_header_parser.sv -----
// Self-checking testbench for the MP3 frame header parser with a built-in stream predictor.
module tb_mp3_frame_header_parser
    import mp3fhp_pkg::*;
();

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  version;
        logic [8:0]  kbps;
        logic [15:0] hz;
        logic        pad;
        logic [1:0]  chans;
        logic [10:0] frame_len;
        logic [29:0] offset;
    } t_frame_info;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_BYTES   = 1500;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = '0;
    logic        i_first_byte = 1'b0;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_status;
    logic [1:0]  o_mpeg_version;
    logic [8:0]  o_bitrate_kbps;
    logic [15:0] o_sample_rate_hz;
    logic        o_padding_bit;
    logic [1:0]  o_channel_count;
    logic [10:0] o_frame_bytes;
    logic [29:0] o_audio_offset;

    mp3_frame_header_parser u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_first_byte     (i_first_byte),
        .i_last_byte      (i_last_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_mpeg_version   (o_mpeg_version),
        .o_bitrate_kbps   (o_bitrate_kbps),
        .o_sample_rate_hz (o_sample_rate_hz),
        .o_padding_bit    (o_padding_bit),
        .o_channel_count  (o_channel_count),
        .o_frame_bytes    (o_frame_bytes),
        .o_audio_offset   (o_audio_offset)
    );

    int unsigned kbps_by_index [2][16] = '{
        '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0},
        '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}
    };
    int unsigned hz_by_index [2][3] = '{
        '{44100, 48000, 32000},
        '{22050, 24000, 16000}
    };

    t_phase      scan_phase = PH_TAG_UNKNOWN;
    logic [29:0] scan_pos = '0;
    logic [29:0] tag_end = '0;
    logic [31:0] hdr_window = '0;
    bit          stream_done = 1'b0;

    t_frame_info expected_frames[$];
    int          mismatches = 0;
    int          live_bytes = 0;
    int          out_hold = 0;
    int          idle_cycles = 0;
    bit          calm = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic bit frame_sync(input logic [31:0] w);
        return (w[31:24] == 8'hff) && (w[23:21] == 3'b111);
    endfunction

    function automatic t_frame_info decode_frame(input logic [31:0] w);
        t_frame_info r;
        int unsigned lsf, samples, br, sr, fb;
        r = '0;
        r.offset = tag_end;
        case (w[20:19])
            VCODE_MPEG1: r.version = VER_MPEG1;
            VCODE_MPEG2: r.version = VER_MPEG2;
            default: begin
                r.status = STAT_BAD_VERSION;
                return r;
            end
        endcase
        if (w[18:17] != LAYER3_CODE) begin
            r.status = STAT_NOT_LAYER3;
            r.version = '0;
            return r;
        end
        if (w[11:10] == SI_RESERVED) begin
            r.status = STAT_RESERVED_RATE;
            r.version = '0;
            return r;
        end
        lsf = (r.version == VER_MPEG1) ? 0 : 1;
        br = kbps_by_index[lsf][w[15:12]];
        sr = hz_by_index[lsf][w[11:10]];
        samples = (lsf == 0) ? 1152 : 576;
        fb = ((samples * br * 1000) / sr) / 8 + w[9];
        r.status = STAT_OK;
        r.kbps = 9'(br);
        r.hz = 16'(sr);
        r.pad = w[9];
        r.chans = (w[7:6] == MONO_MODE) ? 2'd1 : 2'd2;
        r.frame_len = 11'(fb);
        return r;
    endfunction

    task automatic take_byte(input logic [7:0] b, input logic first, input logic last);
        t_frame_info r;
        bit emit;
        int unsigned p, span;
        emit = 1'b0;
        r = '0;
        if (first) begin
            scan_phase = PH_TAG_UNKNOWN;
            scan_pos = '0;
            tag_end = '0;
            hdr_window = '0;
            stream_done = 1'b0;
        end
        if (stream_done) return;
        live_bytes++;
        p = 32'(scan_pos);
        if (scan_phase != PH_HOLD) hdr_window = {hdr_window[23:0], b};
        case (scan_phase)
            PH_TAG_UNKNOWN: begin
                if (p >= 2)
                    scan_phase = (hdr_window[23:0] == ID3_MAGIC) ? PH_TAG_ID3 : PH_TAG_PLAIN;
            end
            PH_TAG_ID3: begin
                if (p >= 9) begin
                    span = ({24'd0, hdr_window[31:24]} << 21) | ({24'd0, hdr_window[23:16]} << 14)
                         | ({24'd0, hdr_window[15:8]} << 7) | {24'd0, hdr_window[7:0]};
                    tag_end = 30'(span + 10);
                    scan_phase = PH_SEARCH;
                end
            end
            PH_TAG_PLAIN: begin
                if (p >= 3 && frame_sync(hdr_window)) begin
                    if (p >= 9) begin
                        r = decode_frame(hdr_window);
                        emit = 1'b1;
                    end else begin
                        scan_phase = PH_HOLD;
                    end
                end else if (p >= 9) begin
                    scan_phase = PH_SEARCH;
                end
            end
            PH_HOLD: begin
                if (p >= 9) begin
                    r = decode_frame(hdr_window);
                    emit = 1'b1;
                end
            end
            PH_SEARCH: begin
                if (p >= int'(tag_end) + 3 && frame_sync(hdr_window)) begin
                    r = decode_frame(hdr_window);
                    emit = 1'b1;
                end
            end
            default: ;
        endcase
        if (scan_pos != POS_MAX) scan_pos = scan_pos + 1'b1;
        if (!emit && last) begin
            r = '0;
            r.status = (scan_phase == PH_SEARCH) ? STAT_NO_SYNC : STAT_TOO_SHORT;
            r.offset = tag_end;
            emit = 1'b1;
        end
        if (emit) begin
            expected_frames.push_back(r);
            stream_done = 1'b1;
            scan_phase = PH_DONE;
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
        int gap;
        gap = draw_wait();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_data_byte = b;
        i_first_byte = first;
        i_last_byte = last;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        take_byte(b, first, last);
    endtask

    task automatic play_stream(input logic [7:0] s[$], input bit end_mark);
        foreach (s[i]) send_byte(s[i], i == 0, end_mark && i == s.size() - 1);
    endtask

    function automatic logic [31:0] make_header();
        logic [1:0] vcode, layer, si;
        bit well_formed;
        well_formed = ($urandom_range(0, 4) != 0);
        vcode = well_formed ? ($urandom_range(0, 1) ? VCODE_MPEG1 : VCODE_MPEG2) : 2'($urandom);
        layer = well_formed ? LAYER3_CODE : 2'($urandom);
        si = well_formed ? 2'($urandom_range(0, 2)) : 2'($urandom);
        return {8'hff, 3'b111, vcode, layer, 1'($urandom), 4'($urandom), si, 2'($urandom),
                8'($urandom)};
    endfunction

    function automatic void push_header(ref logic [7:0] s[$], input logic [31:0] h);
        s.push_back(h[31:24]);
        s.push_back(h[23:16]);
        s.push_back(h[15:8]);
        s.push_back(h[7:0]);
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_frame_info want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            out_hold = draw_wait();
            if (expected_frames.size() == 0) begin
                $error("result arrived with no request pending a result");
                mismatches++;
            end else begin
                want = expected_frames.pop_front();
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("mpeg_version", 32'(want.version), 32'(o_mpeg_version));
                check_field("bitrate_kbps", 32'(want.kbps), 32'(o_bitrate_kbps));
                check_field("sample_rate_hz", 32'(want.hz), 32'(o_sample_rate_hz));
                check_field("padding_bit", 32'(want.pad), 32'(o_padding_bit));
                check_field("channel_count", 32'(want.chans), 32'(o_channel_count));
                check_field("frame_bytes", 32'(want.frame_len), 32'(o_frame_bytes));
                check_field("audio_offset", 32'(want.offset), 32'(o_audio_offset));
            end
        end
    end

    always @(negedge i_clk) begin
        if (o_out_valid === 1'b1) begin
            i_out_stall = (out_hold > 0);
            if (out_hold > 0) out_hold = out_hold - 1;
        end else begin
            i_out_stall = calm ? 1'b0 : 1'($urandom_range(0, 1));
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic test_short_and_restart();
        send_byte(8'hff, 1'b1, 1'b0);
        send_byte(8'hfb, 1'b0, 1'b0);
        play_stream('{8'hff, 8'hfb, 8'h90, 8'hc4}, 1'b1);
        play_stream('{ID3_MAGIC[23:16]}, 1'b1);
    endtask

    task automatic test_largest_frame();
        play_stream('{8'hff, 8'hfb, 8'hea, 8'hc0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h5a, 8'ha5}, 1'b1);
    endtask

    task automatic test_largest_tag();
        play_stream('{ID3_MAGIC[23:16], ID3_MAGIC[15:8], ID3_MAGIC[7:0], 8'h04, 8'h00, 8'h00,
                      8'hff, 8'hff, 8'hff, 8'hff}, 1'b1);
    endtask

    task automatic test_random_streams();
        logic [7:0] s[$];
        logic [31:0] h;
        int kind, n, stop_at;
        stop_at = live_bytes + RANDOM_BYTES;
        while (live_bytes < stop_at) begin
            s = {};
            calm = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3: begin
                    repeat ($urandom_range(0, 12)) s.push_back(8'($urandom));
                    push_header(s, make_header());
                    repeat ($urandom_range(0, 3)) s.push_back(8'($urandom));
                    play_stream(s, $urandom_range(0, 3) != 0);
                end
                4, 5: begin
                    n = $urandom_range(0, 15);
                    s = '{ID3_MAGIC[23:16], ID3_MAGIC[15:8], ID3_MAGIC[7:0], 8'($urandom),
                          8'($urandom), 8'($urandom), 8'h00, 8'h00, 8'h00, 8'(n)};
                    repeat (n + $urandom_range(0, 4)) s.push_back(8'($urandom));
                    push_header(s, make_header());
                    repeat ($urandom_range(0, 3)) s.push_back(8'($urandom));
                    play_stream(s, $urandom_range(0, 3) != 0);
                end
                6: begin
                    s = '{ID3_MAGIC[23:16], ID3_MAGIC[15:8], ID3_MAGIC[7:0], 8'($urandom),
                          8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom)};
                    repeat ($urandom_range(0, 20)) s.push_back(8'($urandom));
                    play_stream(s, 1'b1);
                end
                7: begin
                    n = $urandom_range(1, 9);
                    if ($urandom_range(0, 1)) push_header(s, make_header());
                    while (s.size() < n) s.push_back(8'($urandom));
                    while (s.size() > n) s.pop_back();
                    play_stream(s, 1'b1);
                end
                8: begin
                    repeat ($urandom_range(10, 30)) s.push_back(8'($urandom_range(0, 254)));
                    play_stream(s, 1'b1);
                end
                default: begin
                    repeat ($urandom_range(1, 20)) begin
                        h = $urandom;
                        send_byte(h[7:0], h[10:8] == 3'd0, h[13:11] == 3'd0);
                    end
                end
            endcase
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_short_and_restart();
        test_largest_frame();
        test_largest_tag();
        test_random_streams();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_frames.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
